/* rtl/core/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg: shared definitions for the pursuit position stepper
// Field widths, fixed-point constants and divider reciprocals.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int COORD_W = 40;  // Q8.31 coordinate
	localparam int SPEED_W = 16;
	localparam int MAG_W   = 47;  // magnitude of a scaled delta
	localparam int CW      = 50;  // CORDIC datapath, signed
	localparam int COEF_W  = 31;  // cos / sin, Q1.30, non-negative
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int NUM_W   = 49;
	localparam int REM_W   = 19;
	localparam int DEN_W   = 17;
	localparam int NORM_BIT = 46;
	localparam int NUM_DROP = 17; // low numerator bits dropped before the reciprocal
	localparam int RECIP_SH = 32;

	localparam logic [COEF_W-1:0] Q30_ONE  = COEF_W'(1) << 30;
	localparam logic signed [CW-1:0] INV_GAIN = CW'(652032874);

	localparam logic [DEN_W-1:0] DEN_X  = DEN_W'(110000);
	localparam logic [DEN_W-1:0] DEN_Y  = DEN_W'(86000);
	localparam logic [DEN_W-1:0] HALF_X = DEN_W'(110000 / 2);
	localparam logic [DEN_W-1:0] HALF_Y = DEN_W'(86000 / 2);

	// floor(2^49 / D): quotient estimate lands at most three below the true one
	localparam logic [MUL_W-1:0] RECIP_X = MUL_W'((64'd1 << 49) / 64'd110000);
	localparam logic [MUL_W-1:0] RECIP_Y = MUL_W'((64'd1 << 49) / 64'd86000);

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

endpackage

/* rtl/core/pps_cfg_if.sv */
// ----------------------------------------------------------------------------
// pps_cfg_if: configuration write channel
// Carries the speed register value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pps_cfg_if;
	import pps_pkg::*;

	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] speed;

	modport source (output valid, speed, input ready);
	modport sink   (input valid, speed, output ready);

endinterface

/* rtl/core/pps_req_if.sv */
// ----------------------------------------------------------------------------
// pps_req_if: request channel
// Carries the mode and the start or target point of one item.
// ----------------------------------------------------------------------------
interface pps_req_if;
	import pps_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;

	modport source (output valid, mode, point_x, point_y, input ready);
	modport sink   (input valid, mode, point_x, point_y, output ready);

endinterface

/* rtl/core/pps_rsp_if.sv */
// ----------------------------------------------------------------------------
// pps_rsp_if: response channel
// Carries the missile position after one item.
// ----------------------------------------------------------------------------
interface pps_rsp_if;
	import pps_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] missile_x;
	logic signed [COORD_W-1:0] missile_y;

	modport source (output valid, missile_x, missile_y, input ready);
	modport sink   (input valid, missile_x, missile_y, output ready);

endinterface

/* rtl/core/pursuit_position_step.sv */
// ----------------------------------------------------------------------------
// pursuit_position_step: missile position stepper toward a target point
// Holds the missile position in signed Q8.31 degrees. A load item (mode 0)
// sets the position and passes through the done state into the output
// register. A step item (mode 1) whose deltas are both zero holds the
// position and passes through the scale and done states. Any other step
// item scales the deltas by 110 and 86, normalizes them, runs one CORDIC
// vectoring pass and one rotation pass through a single shared shift-add
// unit, then forms each move through one shared 33x33 multiplier: speed
// times coefficient, a reciprocal estimate of the quotient and up to three
// corrections. A step item with exactly one zero delta skips normalization
// and both passes. The block takes one item at a time. A finished result
// sits in an output register, so the next item is accepted while it waits.
// The speed register is always ready for writes.
// ----------------------------------------------------------------------------
module pursuit_position_step #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	pps_cfg_if.sink   cfg,
	pps_req_if.sink   req,
	pps_rsp_if.source rsp
);
	import pps_pkg::*;

	localparam int IW = $clog2(CORDIC_STEPS);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_SCALE = 12'b0000_0000_0010,
		ST_NORM  = 12'b0000_0000_0100,
		ST_VEC   = 12'b0000_0000_1000,
		ST_ROT   = 12'b0000_0001_0000,
		ST_MCOEF = 12'b0000_0010_0000,
		ST_MNUM  = 12'b0000_0100_0000,
		ST_MQ    = 12'b0000_1000_0000,
		ST_MR    = 12'b0001_0000_0000,
		ST_REM   = 12'b0010_0000_0000,
		ST_CORR  = 12'b0100_0000_0000,
		ST_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t                    st_q;
	logic [SPEED_W-1:0]        speed_q;
	logic signed [COORD_W-1:0] pos_x_q, pos_y_q;
	logic signed [COORD_W-1:0] tgt_x_q, tgt_y_q;
	logic signed [CW-1:0]      cx_q, cy_q;
	logic [CORDIC_STEPS-1:0]   dirs_q;
	logic [IW-1:0]             iter_q;
	logic [COEF_W-1:0]         coef_c_q, coef_s_q;
	logic                      chan_q;
	logic [PROD_W-1:0]         prod_q;
	logic [NUM_W-1:0]          num_q;
	logic [MUL_W-1:0]          quo_q;
	logic [REM_W-1:0]          rem_q;
	logic                      rsp_valid_q;
	logic signed [COORD_W-1:0] rsp_x_q, rsp_y_q;

	logic                      req_acc, rsp_load;
	logic signed [COORD_W:0]   dx_diff, dy_diff;
	logic [COORD_W-1:0]        mag_x, mag_y;
	logic [MAG_W-1:0]          abs_dx, abs_dy;
	logic                      norm_done, norm_far;
	logic signed [CW-1:0]      sh_x, sh_y, rot_x, rot_y;
	logic                      add_y, last_iter;
	logic [COEF_W-1:0]         coef_cur;
	logic [DEN_W-1:0]          den_cur, half_cur;
	logic [MUL_W-1:0]          recip_cur;
	logic [MUL_W-1:0]          mul_a, mul_b;
	logic [PROD_W-1:0]         mul_p;
	logic [NUM_W-1:0]          rem_full;
	logic                      rem_big;
	logic [COORD_W-1:0]        step_amt;

	assign req_acc   = req.valid && req.ready;
	assign req.ready = (st_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.missile_x = rsp_x_q;
	assign rsp.missile_y = rsp_y_q;
	assign rsp_load  = (st_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// scaled delta magnitudes: x*110 = x*128 - x*16 - x*2, y*86 = y*(64+16+4+2)
	assign dx_diff = {tgt_x_q[COORD_W-1], tgt_x_q} - {pos_x_q[COORD_W-1], pos_x_q};
	assign dy_diff = {tgt_y_q[COORD_W-1], tgt_y_q} - {pos_y_q[COORD_W-1], pos_y_q};
	assign mag_x = dx_diff[COORD_W] ? COORD_W'(-dx_diff) : dx_diff[COORD_W-1:0];
	assign mag_y = dy_diff[COORD_W] ? COORD_W'(-dy_diff) : dy_diff[COORD_W-1:0];
	assign abs_dx = (MAG_W'(mag_x) << 7) - (MAG_W'(mag_x) << 4) - (MAG_W'(mag_x) << 1);
	assign abs_dy = (MAG_W'(mag_y) << 6) + (MAG_W'(mag_y) << 4)
		+ (MAG_W'(mag_y) << 2) + (MAG_W'(mag_y) << 1);

	assign norm_done = cx_q[NORM_BIT] | cy_q[NORM_BIT];
	assign norm_far  = ~|cx_q[NORM_BIT:NORM_BIT-8] & ~|cy_q[NORM_BIT:NORM_BIT-8];

	// shared CORDIC micro-rotation; pass one records directions, pass two replays them
	assign sh_x  = cx_q >>> iter_q;
	assign sh_y  = cy_q >>> iter_q;
	assign add_y = (st_q == ST_VEC) ? ~cy_q[CW-1] : ~dirs_q[0];
	assign rot_x = add_y ? cx_q + sh_y : cx_q - sh_y;
	assign rot_y = add_y ? cy_q - sh_x : cy_q + sh_x;
	assign last_iter = (iter_q == IW'(CORDIC_STEPS - 1));

	assign coef_cur  = chan_q ? coef_s_q : coef_c_q;
	assign den_cur   = chan_q ? DEN_Y : DEN_X;
	assign half_cur  = chan_q ? HALF_Y : HALF_X;
	assign recip_cur = chan_q ? RECIP_Y : RECIP_X;

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			ST_MCOEF: begin
				mul_a = MUL_W'(speed_q);
				mul_b = MUL_W'(coef_cur);
			end
			ST_MQ: begin
				mul_a = MUL_W'(num_q[NUM_W-1:NUM_DROP]);
				mul_b = recip_cur;
			end
			ST_MR: begin
				mul_a = prod_q[RECIP_SH+MUL_W-1:RECIP_SH];
				mul_b = MUL_W'(den_cur);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign rem_full = num_q - prod_q[NUM_W-1:0];
	assign rem_big  = (rem_q >= REM_W'(den_cur));
	assign step_amt = COORD_W'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			speed_q     <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			rsp_valid_q <= 1'b0;
			iter_q      <= '0;
			dirs_q      <= '0;
			chan_q      <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				speed_q <= cfg.speed;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req.mode == MODE_LOAD) begin
							pos_x_q <= req.point_x;
							pos_y_q <= req.point_y;
							st_q    <= ST_DONE;
						end else begin
							st_q <= ST_SCALE;
						end
					end
				end
				ST_SCALE: begin
					chan_q <= 1'b0;
					iter_q <= '0;
					if (mag_x == '0 && mag_y == '0) begin
						st_q <= ST_DONE;  // hold position
					end else if (mag_x == '0 || mag_y == '0) begin
						st_q <= ST_MCOEF;
					end else begin
						st_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (norm_done) begin
						st_q <= ST_VEC;
					end
				end
				ST_VEC: begin
					dirs_q <= {add_y, dirs_q[CORDIC_STEPS-1:1]};
					if (last_iter) begin
						iter_q <= '0;
						st_q   <= ST_ROT;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_ROT: begin
					dirs_q <= {1'b0, dirs_q[CORDIC_STEPS-1:1]};
					if (last_iter) begin
						iter_q <= '0;
						st_q   <= ST_MCOEF;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_MCOEF: st_q <= ST_MNUM;
				ST_MNUM:  st_q <= ST_MQ;
				ST_MQ:    st_q <= ST_MR;
				ST_MR:    st_q <= ST_REM;
				ST_REM:   st_q <= ST_CORR;
				ST_CORR: begin
					if (!rem_big) begin
						// equal to target takes the subtract side
						if (!chan_q) begin
							pos_x_q <= (pos_x_q < tgt_x_q) ? pos_x_q + step_amt
								: pos_x_q - step_amt;
							chan_q  <= 1'b1;
							st_q    <= ST_MCOEF;
						end else begin
							pos_y_q <= (pos_y_q < tgt_y_q) ? pos_y_q + step_amt
								: pos_y_q - step_amt;
							st_q    <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			tgt_x_q <= req.point_x;
			tgt_y_q <= req.point_y;
		end
		if (rsp_load) begin
			rsp_x_q <= pos_x_q;
			rsp_y_q <= pos_y_q;
		end
		case (st_q)
			ST_SCALE: begin
				cx_q <= CW'(abs_dx);
				cy_q <= CW'(abs_dy);
				if (mag_x == '0) begin
					coef_c_q <= '0;
					coef_s_q <= Q30_ONE;
				end else begin
					coef_c_q <= Q30_ONE;
					coef_s_q <= '0;
				end
			end
			ST_NORM: begin
				if (!norm_done) begin
					cx_q <= norm_far ? cx_q <<< 8 : cx_q <<< 1;
					cy_q <= norm_far ? cy_q <<< 8 : cy_q <<< 1;
				end
			end
			ST_VEC: begin
				if (last_iter) begin
					cx_q <= INV_GAIN;
					cy_q <= '0;
				end else begin
					cx_q <= rot_x;
					cy_q <= rot_y;
				end
			end
			ST_ROT: begin
				cx_q <= rot_x;
				cy_q <= rot_y;
				if (last_iter) begin
					// clamp slightly negative results to zero
					coef_c_q <= rot_x[CW-1] ? '0 : rot_x[COEF_W-1:0];
					coef_s_q <= rot_y[CW-1] ? '0 : rot_y[COEF_W-1:0];
				end
			end
			ST_MCOEF: prod_q <= mul_p;
			ST_MNUM:  num_q  <= {prod_q[NUM_W-2:0], 1'b0} + NUM_W'(half_cur);
			ST_MQ:    prod_q <= mul_p;
			ST_MR: begin
				quo_q  <= prod_q[RECIP_SH+MUL_W-1:RECIP_SH];
				prod_q <= mul_p;
			end
			ST_REM:   rem_q  <= rem_full[REM_W-1:0];
			ST_CORR: begin
				if (rem_big) begin
					rem_q <= rem_q - REM_W'(den_cur);
					quo_q <= quo_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while an item is in flight");

	a_norm_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_VEC) && (iter_q == '0) |-> (cx_q[NORM_BIT] || cy_q[NORM_BIT]))
		else $error("vectoring started on unnormalized deltas");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CORR) |-> (rem_q < {den_cur, 2'b00}))
		else $error("quotient estimate off by more than three");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(st_q == ST_DONE))
		else $error("response raised outside the done state");

endmodule
